[rtl/glcm_pkg.sv]
// ----------------------------------------------------------------------------
// glcm_pkg
// Shared constants, widths and controller/datapath bundles for the GLCM
// texture metrics block.
// ----------------------------------------------------------------------------
package glcm_pkg;

    localparam int GRAY_LEVELS   = 256;
    localparam int DIRECTIONS    = 8;
    localparam int COUNT_BITS    = 20;
    localparam int FRACTION_BITS = 16;

    // Fixed field widths of the beats
    localparam int LEVEL_BITS       = 8;
    localparam int COUNT_FIELD_BITS = 20;
    localparam int DIR_FIELD_BITS   = 3;
    localparam int SUM_BITS         = 56;
    localparam int HOMOG_BITS       = 63;

    // Derived widths
    localparam int CNT_W         = (COUNT_BITS < COUNT_FIELD_BITS) ? COUNT_BITS
                                                                   : COUNT_FIELD_BITS;
    localparam int D2_BITS       = 2 * LEVEL_BITS;
    localparam int DEN_BITS      = D2_BITS + 1;
    localparam int C2_BITS       = 2 * CNT_W;
    localparam int CT_BITS       = D2_BITS + CNT_W;
    localparam int DIVIDEND_BITS = C2_BITS + FRACTION_BITS;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);
    localparam int DIR_BITS      = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
    localparam int HT_W          = ((DIVIDEND_BITS > HOMOG_BITS) ? DIVIDEND_BITS
                                                                 : HOMOG_BITS) + 1;

    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [HOMOG_BITS-1:0] HOMOG_MAX = {HOMOG_BITS{1'b1}};

    typedef struct packed {
        logic                capture;
        logic                square;
        logic                mul;
        logic                div_step;
        logic                acc;
        logic                emit;
        logic                clear;
        logic [DIR_BITS-1:0] dir;
    } glcm_cmd_t;

    typedef struct packed {
        logic d2_zero;
        logic last;
        logic out_free;
    } glcm_stat_t;

endpackage

[rtl/glcm_if.sv]
// ----------------------------------------------------------------------------
// glcm_entry_if / glcm_result_if
// Valid/ready channels for matrix entry beats and metric result beats.
// ----------------------------------------------------------------------------
interface glcm_entry_if;
    logic                                   valid;
    logic                                   ready;
    logic [glcm_pkg::LEVEL_BITS-1:0]        row_level;
    logic [glcm_pkg::LEVEL_BITS-1:0]        col_level;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg0;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg45;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg90;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg135;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg180;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg225;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg270;
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0]  count_deg315;
    logic                                   last_entry;

    modport source (output valid, row_level, col_level, count_deg0, count_deg45,
                    count_deg90, count_deg135, count_deg180, count_deg225,
                    count_deg270, count_deg315, last_entry, input ready);
    modport sink   (input valid, row_level, col_level, count_deg0, count_deg45,
                    count_deg90, count_deg135, count_deg180, count_deg225,
                    count_deg270, count_deg315, last_entry, output ready);
endinterface

interface glcm_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [glcm_pkg::DIR_FIELD_BITS-1:0]   direction;
    logic [glcm_pkg::SUM_BITS-1:0]         contrast;
    logic [glcm_pkg::SUM_BITS-1:0]         energy;
    logic [glcm_pkg::HOMOG_BITS-1:0]       homogeneity;
    logic                                  last_result;

    modport source (output valid, direction, contrast, energy, homogeneity,
                    last_result, input ready);
    modport sink   (input valid, direction, contrast, energy, homogeneity,
                    last_result, output ready);
endinterface

[rtl/glcm_texture_metrics.sv]
// ----------------------------------------------------------------------------
// glcm_texture_metrics
// Haralick contrast, energy and homogeneity over eight co-occurrence matrices.
// ----------------------------------------------------------------------------
// Entry beats: a new entry is taken only once the previous one is done; an
//   entry whose two levels match skips the divider. The shared radix-2
//   homogeneity divider (56 steps per direction) sets the entry rate.
// Results: once the last entry is accumulated, one result beat per cycle
//   while the sink keeps ready high.
// Reset: rst_n clears the sequencer, the output valid and all sums at once.
// ----------------------------------------------------------------------------
module glcm_texture_metrics (
    input  logic          clk,
    input  logic          rst_n,
    glcm_entry_if.sink    entry,
    glcm_result_if.source metrics
);

    // Command and status bundles between sequencer and datapath
    glcm_pkg::glcm_cmd_t  cmd;
    glcm_pkg::glcm_stat_t stat;

    // Sequencer: holds entry ready low from capture until the last
    // direction is accumulated, or until every result beat is loaded.
    glcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (entry.valid),
        .in_ready (entry.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: multiply, divide, saturate and present results.
    glcm_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (entry),
        .metrics (metrics),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

[rtl/glcm_ctrl.sv]
// ----------------------------------------------------------------------------
// glcm_ctrl
// Sequencer: walks directions, counts divider steps, drives result emission.
// ----------------------------------------------------------------------------
module glcm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  glcm_pkg::glcm_stat_t stat,
    output glcm_pkg::glcm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_MUL,
        S_DIV,
        S_ACC,
        S_EMIT
    } state_t;

    state_t                             state_reg;
    logic [glcm_pkg::DIR_BITS-1:0]      dir_reg;
    logic [glcm_pkg::STEP_BITS-1:0]     step_reg;
    logic                               dir_last;
    logic                               step_last;

    assign dir_last  = (dir_reg == glcm_pkg::DIR_BITS'(glcm_pkg::DIRECTIONS - 1));
    assign step_last = (step_reg == glcm_pkg::STEP_BITS'(glcm_pkg::DIVIDEND_BITS - 1));
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.dir      = dir_reg;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.square   = (state_reg == S_SQUARE);
        cmd.mul      = (state_reg == S_MUL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.acc      = (state_reg == S_ACC);
        cmd.emit     = (state_reg == S_EMIT) && stat.out_free;
        cmd.clear    = (state_reg == S_EMIT) && stat.out_free && dir_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dir_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dir_reg   <= '0;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    step_reg  <= '0;
                    state_reg <= stat.d2_zero ? S_ACC : S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_last)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (dir_last)
                    begin
                        dir_reg   <= '0;
                        state_reg <= stat.last ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        dir_reg   <= dir_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        if (dir_last)
                        begin
                            dir_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            dir_reg <= dir_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/glcm_dp.sv]
// ----------------------------------------------------------------------------
// glcm_dp
// Datapath: entry capture, shared multipliers, radix-2 divider, saturating
// per-direction sums and the result output register.
// ----------------------------------------------------------------------------
module glcm_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    glcm_entry_if.sink            entry,
    glcm_result_if.source         metrics,
    input  glcm_pkg::glcm_cmd_t   cmd,
    output glcm_pkg::glcm_stat_t  stat
);

    localparam int DIRS = glcm_pkg::DIRECTIONS;

    logic [glcm_pkg::CNT_W-1:0]          cnt_reg [DIRS];
    logic [glcm_pkg::COUNT_FIELD_BITS-1:0] cnt_in [8];
    logic [glcm_pkg::LEVEL_BITS-1:0]     diff_reg;
    logic                                last_reg;
    logic [glcm_pkg::D2_BITS-1:0]        d2_reg;
    logic [glcm_pkg::DEN_BITS-1:0]       den_reg;
    logic [glcm_pkg::C2_BITS-1:0]        c2_reg;
    logic [glcm_pkg::CT_BITS-1:0]        ct_reg;
    logic [glcm_pkg::DIVIDEND_BITS-1:0]  quot_reg;
    logic [glcm_pkg::DEN_BITS-1:0]       rem_reg;

    logic [glcm_pkg::SUM_BITS-1:0]       con_sum_reg [DIRS];
    logic [glcm_pkg::SUM_BITS-1:0]       ene_sum_reg [DIRS];
    logic [glcm_pkg::HOMOG_BITS-1:0]     hom_sum_reg [DIRS];

    logic                                out_valid_reg;
    logic [glcm_pkg::DIR_FIELD_BITS-1:0] out_dir_reg;
    logic [glcm_pkg::SUM_BITS-1:0]       out_con_reg;
    logic [glcm_pkg::SUM_BITS-1:0]       out_ene_reg;
    logic [glcm_pkg::HOMOG_BITS-1:0]     out_hom_reg;
    logic                                out_last_reg;

    logic [glcm_pkg::LEVEL_BITS-1:0]     row_c;
    logic [glcm_pkg::LEVEL_BITS-1:0]     col_c;
    logic [glcm_pkg::CNT_W-1:0]          cnt_sel;
    logic [glcm_pkg::C2_BITS-1:0]        c2_w;
    logic [glcm_pkg::DEN_BITS:0]         rem_sh;
    logic                                rem_ge;
    logic [glcm_pkg::SUM_BITS:0]         con_add;
    logic [glcm_pkg::SUM_BITS:0]         ene_add;
    logic [glcm_pkg::HT_W-1:0]           hom_term;
    logic [glcm_pkg::HT_W-1:0]           hom_add;

    assign cnt_in[0] = entry.count_deg0;
    assign cnt_in[1] = entry.count_deg45;
    assign cnt_in[2] = entry.count_deg90;
    assign cnt_in[3] = entry.count_deg135;
    assign cnt_in[4] = entry.count_deg180;
    assign cnt_in[5] = entry.count_deg225;
    assign cnt_in[6] = entry.count_deg270;
    assign cnt_in[7] = entry.count_deg315;

    // Clamp levels beyond the configured gray range
    assign row_c = (32'(entry.row_level) >= glcm_pkg::GRAY_LEVELS)
                 ? glcm_pkg::LEVEL_BITS'(glcm_pkg::GRAY_LEVELS - 1) : entry.row_level;
    assign col_c = (32'(entry.col_level) >= glcm_pkg::GRAY_LEVELS)
                 ? glcm_pkg::LEVEL_BITS'(glcm_pkg::GRAY_LEVELS - 1) : entry.col_level;

    assign cnt_sel = cnt_reg[cmd.dir];
    assign c2_w    = glcm_pkg::C2_BITS'(cnt_sel * cnt_sel);

    // One restoring divide step
    assign rem_sh = {rem_reg, quot_reg[glcm_pkg::DIVIDEND_BITS-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    assign con_add  = {1'b0, con_sum_reg[cmd.dir]}
                    + (glcm_pkg::SUM_BITS + 1)'(ct_reg);
    assign ene_add  = {1'b0, ene_sum_reg[cmd.dir]}
                    + (glcm_pkg::SUM_BITS + 1)'(c2_reg);
    assign hom_term = (glcm_pkg::HT_W'(quot_reg) > glcm_pkg::HT_W'(glcm_pkg::HOMOG_MAX))
                    ? glcm_pkg::HT_W'(glcm_pkg::HOMOG_MAX) : glcm_pkg::HT_W'(quot_reg);
    assign hom_add  = glcm_pkg::HT_W'(hom_sum_reg[cmd.dir]) + hom_term;

    assign stat.d2_zero  = (d2_reg == '0);
    assign stat.last     = last_reg;
    assign stat.out_free = !out_valid_reg || metrics.ready;

    assign metrics.valid       = out_valid_reg;
    assign metrics.direction   = out_dir_reg;
    assign metrics.contrast    = out_con_reg;
    assign metrics.energy      = out_ene_reg;
    assign metrics.homogeneity = out_hom_reg;
    assign metrics.last_result = out_last_reg;

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int k = 0; k < DIRS; k++)
            begin
                cnt_reg[k] <= cnt_in[k][glcm_pkg::CNT_W-1:0];
            end
            diff_reg <= (row_c >= col_c) ? (row_c - col_c) : (col_c - row_c);
            last_reg <= entry.last_entry;
        end
        if (cmd.square)
        begin
            d2_reg  <= glcm_pkg::D2_BITS'(diff_reg * diff_reg);
            den_reg <= glcm_pkg::DEN_BITS'(diff_reg * diff_reg) + 1'b1;
        end
        if (cmd.mul)
        begin
            c2_reg   <= c2_w;
            ct_reg   <= glcm_pkg::CT_BITS'(d2_reg * cnt_sel);
            quot_reg <= {c2_w, {glcm_pkg::FRACTION_BITS{1'b0}}};
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? glcm_pkg::DEN_BITS'(rem_sh - {1'b0, den_reg})
                               : rem_sh[glcm_pkg::DEN_BITS-1:0];
            quot_reg <= {quot_reg[glcm_pkg::DIVIDEND_BITS-2:0], rem_ge};
        end
    end

    // Per-direction sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIRS; k++)
            begin
                con_sum_reg[k] <= '0;
                ene_sum_reg[k] <= '0;
                hom_sum_reg[k] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < DIRS; k++)
            begin
                con_sum_reg[k] <= '0;
                ene_sum_reg[k] <= '0;
                hom_sum_reg[k] <= '0;
            end
        end
        else if (cmd.acc)
        begin
            con_sum_reg[cmd.dir] <= con_add[glcm_pkg::SUM_BITS] ? glcm_pkg::SUM_MAX
                                  : con_add[glcm_pkg::SUM_BITS-1:0];
            ene_sum_reg[cmd.dir] <= ene_add[glcm_pkg::SUM_BITS] ? glcm_pkg::SUM_MAX
                                  : ene_add[glcm_pkg::SUM_BITS-1:0];
            hom_sum_reg[cmd.dir] <= (hom_add > glcm_pkg::HT_W'(glcm_pkg::HOMOG_MAX))
                                  ? glcm_pkg::HOMOG_MAX
                                  : hom_add[glcm_pkg::HOMOG_BITS-1:0];
        end
    end

    // Result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (metrics.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_dir_reg  <= glcm_pkg::DIR_FIELD_BITS'(cmd.dir);
            out_con_reg  <= con_sum_reg[cmd.dir];
            out_ene_reg  <= ene_sum_reg[cmd.dir];
            out_hom_reg  <= hom_sum_reg[cmd.dir];
            out_last_reg <= (cmd.dir == glcm_pkg::DIR_BITS'(DIRS - 1));
        end
    end

endmodule

[rtl/glcm_checker.sv]
// ----------------------------------------------------------------------------
// glcm_checker
// Port-level checks for the GLCM texture metrics block.
// ----------------------------------------------------------------------------
module glcm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [glcm_pkg::DIR_FIELD_BITS-1:0] out_direction,
    input logic [glcm_pkg::SUM_BITS-1:0]       out_contrast,
    input logic                                out_last
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_direction)
                                    && $stable(out_contrast))
        else $error("result beat changed under stall");

    // Final beat carries the top direction
    a_last_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |->
            out_direction == glcm_pkg::DIR_FIELD_BITS'(glcm_pkg::DIRECTIONS - 1))
        else $error("last result on wrong direction");

    // No entry taken while the result run still has beats to load
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("entry ready during result run");

    // Entry ready is low right after an entry is accepted
    a_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("entry ready right after accept");

endmodule

bind glcm_texture_metrics glcm_checker u_glcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (entry.valid),
    .in_ready      (entry.ready),
    .out_valid     (metrics.valid),
    .out_ready     (metrics.ready),
    .out_direction (metrics.direction),
    .out_contrast  (metrics.contrast),
    .out_last      (metrics.last_result)
);
